>>> sv/bce_pkg.sv
// Shared types and constants for the binary cross erosion core.
package bce_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 11;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [PIX_W-1:0] pix_t;

  // Registered read data from the line buffer for the item just accepted.
  typedef struct packed {
    pix_t cur;         // previous row, same column
    pix_t nxt;         // previous row, next column
    logic above_zero;  // row above previous row is zero at this column
  } lb_rd_t;

  // Zero-flag write-back from the output stage.
  typedef struct packed {
    logic we;
    col_t col;
    logic val;
  } lb_flag_wr_t;

endpackage

>>> sv/bce_line_buf.sv
// Line buffer: pixel row memory and above-zero flag memory, registered reads.
module bce_line_buf (
  input  logic                 clk,
  input  logic                 pix_we,
  input  bce_pkg::col_t        pix_col,
  input  bce_pkg::pix_t        pix_wr,
  input  bce_pkg::lb_flag_wr_t flag_wr,
  output bce_pkg::lb_rd_t      rd
);
  import bce_pkg::*;

  pix_t pix_mem [MAX_WIDTH];
  logic az_mem  [MAX_WIDTH];
  col_t nxt_col;

  assign nxt_col = (pix_col == col_t'(MAX_WIDTH - 1)) ? '0 : pix_col + col_t'(1);

  always_ff @(posedge clk) begin
    if (flag_wr.we) begin
      az_mem[flag_wr.col] <= flag_wr.val;
    end
    if (pix_we) begin
      pix_mem[pix_col] <= pix_wr;
      rd.cur <= pix_mem[pix_col];
      rd.nxt <= pix_mem[nxt_col];
      // forward a flag written on the same edge (single-column frames)
      rd.above_zero <= (flag_wr.we && flag_wr.col == pix_col) ? flag_wr.val
                                                              : az_mem[pix_col];
    end
  end

endmodule

>>> sv/binary_cross_erosion_core.sv
// Top level: streaming 4-neighbor binary erosion over a raster frame.
//
//   channel  direction  handshake             beat contents
//   in       input      in_valid / in_stall   pixel_in
//   out      output     out_valid / out_stall pixel_out, run_last, frame_end
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// One pixel per clock unless stalled; a taken beat is registered in stage 1,
// then in the output register. Results appear a row behind the input. In the
// last row the first pixel gives one result, each later one gives two results
// (three on the final one) and holds input until done, one per cycle unless stalled.
// rst clears control state only; line buffer entries are always written in a
// frame before they are read. Output stall backs up into in_stall.
module binary_cross_erosion_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  bce_pkg::dim_t               cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bce_pkg::pix_t               pixel_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bce_pkg::pix_t               pixel_out,
  output logic                        run_last,
  output logic                        frame_end
);
  import bce_pkg::*;

  dim_t frame_width;
  dim_t frame_height;
  col_t w_last;
  row_t h_last;
  col_t col;
  row_t row;

  logic in_acc;
  logic [2:0] rem_init;

  // stage 1 (item whose line buffer reads are ready)
  logic       s1_valid;
  logic [2:0] s1_rem;
  col_t       s1_col;
  logic       s1_r_ge1;
  logic       s1_r_ge2;
  logic       s1_c_ge1;
  logic       s1_c_ge2;
  logic       s1_c_last;
  pix_t       s1_px;
  pix_t       s1_px1;
  pix_t       s1_px2;
  pix_t       left_val;

  lb_rd_t      lb_rd;
  lb_flag_wr_t flag_wr;

  logic       slot_free;
  logic       emit;
  logic       s1_done;
  logic [2:0] pick;
  logic [2:0] rem_after;
  logic       kill_a;
  logic       kill_b;
  logic       kill_c;
  pix_t       res_pix;

  // effective frame size, out-of-range values clamped
  always_comb begin
    if (frame_width == '0) begin
      w_last = '0;
    end else if (frame_width > dim_t'(MAX_WIDTH)) begin
      w_last = col_t'(MAX_WIDTH - 1);
    end else begin
      w_last = col_t'(frame_width - dim_t'(1));
    end
    if (frame_height == '0) begin
      h_last = '0;
    end else if (frame_height > dim_t'(MAX_HEIGHT)) begin
      h_last = row_t'(MAX_HEIGHT - 1);
    end else begin
      h_last = row_t'(frame_height - dim_t'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= dim_t'(MAX_WIDTH);
      frame_height <= dim_t'(MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_acc = in_valid && !in_stall;

  // results an item produces: bit 0 previous row, bit 1 drain, bit 2 final
  assign rem_init = {(row == h_last) && (col == w_last),
                     (row == h_last) && (col != '0),
                     (row != '0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT)) begin
      col <= '0;
      row <= '0;
    end else if (in_acc) begin
      if (col == w_last) begin
        col <= '0;
        row <= (row == h_last) ? '0 : row + row_t'(1);
      end else begin
        col <= col + col_t'(1);
      end
    end
  end

  bce_line_buf u_line_buf (
    .clk     (clk),
    .pix_we  (in_acc),
    .pix_col (col),
    .pix_wr  (pixel_in),
    .flag_wr (flag_wr),
    .rd      (lb_rd)
  );

  // result selection
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    if (s1_rem[0]) begin
      pick = 3'b001;
    end else if (s1_rem[1]) begin
      pick = 3'b010;
    end else begin
      pick = 3'b100;
    end
  end

  assign rem_after = s1_rem & ~pick;
  assign emit      = s1_valid && slot_free && (s1_rem != '0);
  assign s1_done   = s1_valid && ((s1_rem == '0) || (slot_free && rem_after == '0));
  assign in_stall  = s1_valid && !s1_done;

  assign kill_a = (s1_r_ge2 && lb_rd.above_zero) || (s1_px == '0) ||
                  (s1_c_ge1 && left_val == '0) || (!s1_c_last && lb_rd.nxt == '0);
  assign kill_b = (s1_r_ge1 && left_val == '0) || (s1_c_ge2 && s1_px2 == '0) ||
                  (s1_px == '0);
  assign kill_c = (s1_r_ge1 && lb_rd.cur == '0) || (s1_c_ge1 && s1_px1 == '0);

  always_comb begin
    case (pick)
      3'b001:  res_pix = kill_a ? '0 : lb_rd.cur;
      3'b010:  res_pix = kill_b ? '0 : s1_px1;
      3'b100:  res_pix = kill_c ? '0 : s1_px;
      default: res_pix = '0;
    endcase
  end

  assign flag_wr.we  = s1_done && s1_r_ge1;
  assign flag_wr.col = s1_col;
  assign flag_wr.val = (lb_rd.cur == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_rem   <= '0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
      s1_rem   <= rem_init;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
      s1_rem   <= '0;
    end else if (emit) begin
      s1_rem   <= rem_after;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col    <= col;
      s1_r_ge1  <= (row != '0);
      s1_r_ge2  <= (row > row_t'(1));
      s1_c_ge1  <= (col != '0);
      s1_c_ge2  <= (col > col_t'(1));
      s1_c_last <= (col == w_last);
      s1_px     <= pixel_in;
      s1_px1    <= s1_px;
      s1_px2    <= s1_px1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_val <= '0;
    end else if (cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT)) begin
      left_val <= '0;
    end else if (flag_wr.we) begin
      left_val <= lb_rd.cur;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_out <= res_pix;
      run_last  <= (rem_after == '0);
      frame_end <= pick[2];
    end
  end

endmodule
